// ===== hw/rtl/dlar_pkg.sv =====
// Shared types and constants for the display-list address relocator.
// Used by the controller, datapath, top level and checker.
package dlar_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFF_W    = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_TDATA_W  = 2 * WORD_W + 2 * OFF_W;
  localparam int unsigned OUT_TDATA_W = 2 * WORD_W;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 2'd1;

  localparam logic [7:0] OP_MTX      = 8'h01;
  localparam logic [7:0] OP_MOVEMEM  = 8'h03;
  localparam logic [7:0] OP_VTX      = 8'h04;
  localparam logic [7:0] OP_DL       = 8'h06;
  localparam logic [7:0] OP_COL      = 8'h07;
  localparam logic [7:0] OP_ENDDL    = 8'hb8;
  localparam logic [7:0] OP_MOVEWORD = 8'hbc;
  localparam logic [7:0] OP_SETTIMG  = 8'hfd;
  localparam logic [7:0] OP_SETZIMG  = 8'hfe;
  localparam logic [7:0] OP_SETCIMG  = 8'hff;

  localparam logic [3:0] SEG_RELOC = 4'd5;

  typedef struct packed {
    logic [OFF_W-1:0] src;
    logic [OFF_W-1:0] dst;
  } tex_entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic latch_tex;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/dlar_ctrl.sv =====
// Controller state machine: accept, execute (table search), hold, commit.
// Depends on dlar_pkg for the command and status structs.
module dlar_ctrl
  import dlar_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.step = 1'b1;
        if (sts.search_done) begin
          cmd.latch_tex = 1'b1;
          state_nxt     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dlar_datapath.sv =====
// Datapath: item registers, base registers, texture table memory, search
// counter, address rewrite and output register. Depends on dlar_pkg.
module dlar_datapath
  import dlar_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]      in_tuser,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [OFF_W-1:0]       cfg_data,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [STATUS_W-1:0]    out_tuser
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // item held for the duration of one beat's processing
  logic [KIND_W-1:0] kind_r;
  logic [WORD_W-1:0] cmd_r;
  logic [WORD_W-1:0] addr_r;
  logic [OFF_W-1:0]  esrc_r;
  logic [OFF_W-1:0]  edst_r;

  logic [OFF_W-1:0] src_base_r;
  logic [OFF_W-1:0] dst_base_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_vld_r;
  tex_entry_t       q_r;
  logic [OFF_W-1:0] tex_off_r;

  tex_entry_t mem [TABLE_ENTRIES];

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  logic [7:0]          op;
  logic [OFF_W-1:0]    off;
  logic                seg5;
  logic                has_addr;
  logic                segmented;
  logic                needs_search;
  logic                full;
  logic                hit;
  logic                exhausted;
  logic [OFF_W-1:0]    off_new;
  logic [WORD_W-1:0]   addr_new;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                res_last;
  logic [STATUS_W-1:0] res_status;

  always_comb begin
    op        = cmd_r[31:24];
    off       = addr_r[OFF_W-1:0];
    seg5      = (addr_r[27:24] == SEG_RELOC);
    has_addr  = op inside {OP_VTX, OP_COL, OP_MOVEWORD, OP_SETTIMG};
    segmented = op inside {OP_MOVEMEM, OP_MTX, OP_VTX, OP_COL, OP_DL,
                           OP_SETTIMG, OP_SETCIMG, OP_SETZIMG};
    needs_search = (kind_r == KIND_CMD) && (op == OP_SETTIMG) && seg5;
    full      = (count_r == FULL_CNT);
    hit       = rd_vld_r && (q_r.src == off);
    exhausted = !rd_vld_r && (rd_idx_r >= count_r);
  end

  assign sts.search_done = !needs_search || hit || exhausted;
  assign sts.out_free    = !out_tvalid_r || out_tready;

  always_comb begin
    off_new    = off;
    res_status = STATUS_OK;
    res_data   = '0;
    res_last   = 1'b0;
    addr_new   = addr_r;
    case (kind_r)
      KIND_ADD: begin
        if (full) begin
          res_status = STATUS_FULL;
        end
      end
      KIND_CMD: begin
        if (has_addr && seg5) begin
          if (op == OP_SETTIMG) begin
            off_new = tex_off_r;
          end else if (off < src_base_r) begin
            res_status = STATUS_BELOW;
          end else begin
            off_new = off - src_base_r + dst_base_r;
          end
        end
        addr_new    = {addr_r[WORD_W-1:OFF_W], off_new};
        addr_new[0] = addr_new[0] | segmented;
        res_data    = {addr_new, cmd_r};
        res_last    = (op == OP_ENDDL);
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  // item, search pipeline and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_tuser;
      cmd_r  <= in_tdata[WORD_W-1:0];
      addr_r <= in_tdata[2*WORD_W-1:WORD_W];
      esrc_r <= in_tdata[2*WORD_W+OFF_W-1:2*WORD_W];
      edst_r <= in_tdata[2*WORD_W+2*OFF_W-1:2*WORD_W+OFF_W];
    end
    if (cmd.latch_tex) begin
      tex_off_r <= hit ? q_r.dst : '0;
    end
    if (cmd.commit) begin
      out_tdata_r <= res_data;
      out_tlast_r <= res_last;
      out_tuser_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      q_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
    if (cmd.commit && (kind_r == KIND_ADD) && !full) begin
      mem[count_r[IDX_W-1:0]] <= '{src: esrc_r, dst: edst_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r   <= '0;
      dst_base_r   <= '0;
      count_r      <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wen && (cfg_index == REG_SOURCE_BASE)) begin
        src_base_r <= cfg_data;
      end
      if (cfg_wen && (cfg_index == REG_DEST_BASE)) begin
        dst_base_r <= cfg_data;
      end
      if (cmd.load) begin
        rd_idx_r <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.step) begin
        if (rd_idx_r < count_r) begin
          rd_idx_r <= rd_idx_r + 1'b1;
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        if (kind_r == KIND_CLEAR) begin
          count_r <= '0;
        end else if ((kind_r == KIND_ADD) && !full) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hw/rtl/display_list_address_relocator_unit.sv =====
// Top level of the display-list address relocator.
// Instantiates dlar_ctrl and dlar_datapath; depends on dlar_pkg.
//
// Usage:
//   in_*  : one beat per item. in_tuser is the item kind (clear table, add
//           table entry, process command); in_tdata carries the command word,
//           address word and a new table entry's source and destination.
//   out_* : one beat per item. out_tdata is command then rewritten address,
//           out_tlast flags the end-display-list opcode, out_tuser the status.
//   cfg_* : writes source base (index 0) and destination base (index 1);
//           always ready, to be written only while the block is idle.
// One item is in flight at a time; the next is accepted as its result goes valid.
// Clear, add and ordinary commands pass through the execute and hold states
// before a valid result. A set-texture-image command for segment 5 searches
// the table one entry per cycle in the execute state, until a hit or until
// every filled entry is read. Reset empties the table (entry count to zero)
// and clears both bases; no clearing pass is needed. If the receiver stalls,
// the result waits in the output register; one more item is accepted and
// held once processed, then the input stays blocked until the waiting beat
// is taken.
module display_list_address_relocator_unit
  import dlar_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] command_word, [63:32] address_word, [87:64] entry_source,
  // [111:88] entry_dest
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] command_out, [63:32] address_out
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // [1:0] status
  output logic [STATUS_W-1:0]    out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [OFF_W-1:0]       cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  dlar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlar_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/dlar_checker.sv =====
// Port-level checker for the relocator, bound to the top level.
// Depends on dlar_pkg for widths and status codes.
module dlar_checker
  import dlar_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic [STATUS_W-1:0]    out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == STATUS_OK)
    else $error("end of list with error status");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_FULL |-> out_tdata == '0 && !out_tlast)
    else $error("table full result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == STATUS_OK || out_tuser == STATUS_BELOW ||
      out_tuser == STATUS_FULL)
    else $error("undefined status code");

endmodule

bind display_list_address_relocator_unit dlar_checker u_dlar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
